>>> hw/rtl/gla_pkg.sv
// Package for the genotype likelihood accumulator: widths, phred ROM builders, fixed biases.
`default_nettype none

package gla_pkg;

    localparam int QUAL_TABLE_DEPTH = 128;
    localparam int FRAC_BITS        = 8;

    localparam int QUAL_W = 12;
    localparam int QIDX_W = $clog2(QUAL_TABLE_DEPTH);
    localparam int SUM_W  = 32;
    localparam int CNT_W  = 16;
    localparam int PL_W   = 16;
    localparam int GT_W   = 2;

    // 10*log10(3) and 3.0103 - 10*log10(1.1), rounded to the fixed-point grid
    localparam logic [SUM_W-1:0] BIAS_3 =
        SUM_W'(((64'd4771213 << FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic [SUM_W-1:0] BIAS_IHET =
        SUM_W'(((64'd2596373 << FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic [SUM_W-1:0] BIAS_10 = SUM_W'(64'd10 << FRAC_BITS);

    localparam logic [63:0] ONE_Q32          = 64'h1_0000_0000;
    localparam logic [63:0] TENTH_DECADE_Q32 = 64'd3411613790;

    // log2 -> log10 scaling denominator (24 fraction bits of log2)
    localparam logic [63:0] PHRED_DEN  = 64'd10000 << 24;
    localparam logic [63:0] PHRED_HALF = PHRED_DEN / 64'd2;

    typedef enum logic {
        VK_SNP   = 1'b0,
        VK_INDEL = 1'b1
    } variant_kind_t;

    typedef enum logic [GT_W-1:0] {
        GT_HOM_REF = 2'd0,
        GT_HET     = 2'd1,
        GT_HOM_ALT = 2'd2
    } genotype_t;

    typedef logic [SUM_W-1:0] rom_t [QUAL_TABLE_DEPTH];

    // -10*log10(x / 2^32) in Q.FRAC_BITS; evaluated at elaboration only
    function automatic logic [SUM_W-1:0] phred_q32(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] neglog;
        logic [63:0] num;
        int          e;
        x    = x_in;
        frac = 64'd0;
        e    = 0;
        if (x == 64'd0) begin
            return '1;
        end
        if (x > ONE_Q32) begin
            x = ONE_Q32;
        end
        while ((x >> (e + 1)) != 64'd0) begin
            e++;
        end
        m = (e > 30) ? (x >> (e - 30)) : (x << (30 - e));
        for (int i = 0; i < 24; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        neglog = (64'(32 - e) << 24) - frac;
        num    = (neglog * 64'd30103) << FRAC_BITS;
        return SUM_W'((num + PHRED_HALF) / PHRED_DEN);
    endfunction

    function automatic rom_t build_match_rom();
        rom_t        rom;
        logic [63:0] p;
        p = ONE_Q32;
        for (int k = 0; k < QUAL_TABLE_DEPTH; k++) begin
            if (k > 0) begin
                p = (p * TENTH_DECADE_Q32 + (64'd1 << 31)) >> 32;
            end
            rom[k] = phred_q32(ONE_Q32 - p);
        end
        return rom;
    endfunction

    function automatic rom_t build_het_rom();
        rom_t        rom;
        logic [63:0] p;
        p = ONE_Q32;
        for (int k = 0; k < QUAL_TABLE_DEPTH; k++) begin
            if (k > 0) begin
                p = (p * TENTH_DECADE_Q32 + (64'd1 << 31)) >> 32;
            end
            rom[k] = phred_q32((64'd3 * ONE_Q32 - 64'd2 * p + 64'd3) / 64'd6);
        end
        return rom;
    endfunction

    localparam rom_t MATCH_ROM = build_match_rom();
    localparam rom_t HET_ROM   = build_het_rom();

endpackage

`default_nettype wire

>>> hw/rtl/genotype_likelihood_accumulator.sv
// Top level: per-read phred likelihood accumulation and genotype call per variant.
`default_nettype none

// Accepts one read observation per cycle. Each transaction goes through a term
// register (quality clamp and ROM lookup, or the indel closed-form terms), then
// the accumulator update, whose feedback loop on the sums sets the rate of
// one item per clock. An item with last set moves the final sums into a close
// register and clears the accumulators in the same cycle, so the next variant
// can follow without a gap. The result moves from the close register into
// the output register once the output register can take it (free or being
// emptied). The output and close registers each hold a result while new items
// keep flowing in; input stalls only when a third variant closes while both
// earlier results are still waiting.
// variant_kind is written through the cfg port and applies to items accepted
// afterwards; the SNP tables are two constant ROMs of QUAL_TABLE_DEPTH entries.
module genotype_likelihood_accumulator (
    input  wire                          clk,
    input  wire                          rst_n,

    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire                          cfg_data,

    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          has_obs,
    input  wire                          allele_is_ref,
    input  wire  [gla_pkg::QUAL_W-1:0]   quality,
    input  wire                          last,

    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [gla_pkg::PL_W-1:0]     pl_hom_ref,
    output logic [gla_pkg::PL_W-1:0]     pl_het,
    output logic [gla_pkg::PL_W-1:0]     pl_hom_alt,
    output logic [gla_pkg::GT_W-1:0]     genotype,
    output logic [gla_pkg::CNT_W-1:0]    read_depth,
    output logic [gla_pkg::CNT_W-1:0]    nonref_count
);

    import gla_pkg::*;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

    // configuration
    variant_kind_t variant_kind_reg;

    // term stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_has_obs_reg;
    logic              s1_is_ref_reg;
    logic              s1_last_reg;
    logic [SUM_W-1:0]  s1_agree_reg;
    logic [SUM_W-1:0]  s1_het_reg;
    logic [SUM_W-1:0]  s1_oppose_reg;

    // accumulators
    logic [SUM_W-1:0]  sum_hom_ref_reg;
    logic [SUM_W-1:0]  sum_het_reg;
    logic [SUM_W-1:0]  sum_hom_alt_reg;
    logic [CNT_W-1:0]  depth_count_reg;
    logic [CNT_W-1:0]  nonref_tally_reg;
    logic [SUM_W-1:0]  sum_hom_ref_next;
    logic [SUM_W-1:0]  sum_het_next;
    logic [SUM_W-1:0]  sum_hom_alt_next;
    logic [CNT_W-1:0]  depth_count_next;
    logic [CNT_W-1:0]  nonref_tally_next;

    // close stage
    logic              fin_valid_reg;
    logic              fin_valid_next;
    logic [SUM_W-1:0]  fin_hom_ref_reg;
    logic [SUM_W-1:0]  fin_het_reg;
    logic [SUM_W-1:0]  fin_hom_alt_reg;
    logic [CNT_W-1:0]  fin_depth_reg;
    logic [CNT_W-1:0]  fin_nonref_reg;

    // output stage
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [PL_W-1:0]   pl_hom_ref_reg;
    logic [PL_W-1:0]   pl_het_reg;
    logic [PL_W-1:0]   pl_hom_alt_reg;
    genotype_t         genotype_reg;
    logic [CNT_W-1:0]  read_depth_reg;
    logic [CNT_W-1:0]  nonref_count_reg;

    logic              in_fire;
    logic              s1_fire;
    logic              fin_ready;
    logic              out_load;

    // term lookup
    logic [QIDX_W-1:0] qidx;
    logic [SUM_W-1:0]  agree_term;
    logic [SUM_W-1:0]  het_term;
    logic [SUM_W-1:0]  oppose_term;

    // accumulate
    logic [SUM_W-1:0]  add_ref_term;
    logic [SUM_W-1:0]  add_alt_term;
    logic [SUM_W:0]    raw_hom_ref;
    logic [SUM_W:0]    raw_het;
    logic [SUM_W:0]    raw_hom_alt;
    logic [SUM_W-1:0]  upd_hom_ref;
    logic [SUM_W-1:0]  upd_het;
    logic [SUM_W-1:0]  upd_hom_alt;
    logic [CNT_W-1:0]  upd_depth;
    logic [CNT_W-1:0]  upd_nonref;

    // normalize
    logic [SUM_W-1:0]  min_sum;
    genotype_t         gt_pick;
    logic [SUM_W:0]    rnd_hom_ref;
    logic [SUM_W:0]    rnd_het;
    logic [SUM_W:0]    rnd_hom_alt;
    logic [PL_W-1:0]   pl_hom_ref_next;
    logic [PL_W-1:0]   pl_het_next;
    logic [PL_W-1:0]   pl_hom_alt_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_kind_reg <= VK_SNP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            variant_kind_reg <= variant_kind_t'(cfg_data);
        end
    end

    // handshake chain
    assign out_load  = fin_valid_reg && (!out_valid_reg || out_ready);
    assign fin_ready = !fin_valid_reg || out_load;
    assign s1_fire   = s1_valid_reg && (!s1_last_reg || fin_ready);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        if (quality > QUAL_W'(QUAL_TABLE_DEPTH - 1))
        begin
            qidx = QIDX_W'(QUAL_TABLE_DEPTH - 1);
        end
        else
        begin
            qidx = quality[QIDX_W-1:0];
        end

        if (variant_kind_reg == VK_SNP)
        begin
            agree_term  = MATCH_ROM[qidx];
            het_term    = HET_ROM[qidx];
            oppose_term = (SUM_W'(qidx) << FRAC_BITS) + BIAS_3;
        end
        else
        begin
            agree_term  = SUM_W'(quality) << FRAC_BITS;
            het_term    = (SUM_W'(quality) << FRAC_BITS) + BIAS_IHET;
            oppose_term = (SUM_W'(quality) << FRAC_BITS) + BIAS_10;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_has_obs_reg <= has_obs;
            s1_is_ref_reg  <= allele_is_ref;
            s1_last_reg    <= last;
            s1_agree_reg   <= agree_term;
            s1_het_reg     <= het_term;
            s1_oppose_reg  <= oppose_term;
        end
    end

    // saturating accumulate
    always_comb
    begin
        add_ref_term = s1_is_ref_reg ? s1_agree_reg : s1_oppose_reg;
        add_alt_term = s1_is_ref_reg ? s1_oppose_reg : s1_agree_reg;
        raw_hom_ref  = {1'b0, sum_hom_ref_reg} + {1'b0, add_ref_term};
        raw_het      = {1'b0, sum_het_reg} + {1'b0, s1_het_reg};
        raw_hom_alt  = {1'b0, sum_hom_alt_reg} + {1'b0, add_alt_term};

        upd_hom_ref = sum_hom_ref_reg;
        upd_het     = sum_het_reg;
        upd_hom_alt = sum_hom_alt_reg;
        upd_depth   = depth_count_reg;
        upd_nonref  = nonref_tally_reg;
        if (s1_has_obs_reg)
        begin
            upd_hom_ref = raw_hom_ref[SUM_W] ? '1 : raw_hom_ref[SUM_W-1:0];
            upd_het     = raw_het[SUM_W] ? '1 : raw_het[SUM_W-1:0];
            upd_hom_alt = raw_hom_alt[SUM_W] ? '1 : raw_hom_alt[SUM_W-1:0];
            if (depth_count_reg != '1)
            begin
                upd_depth = depth_count_reg + CNT_W'(1);
            end
            if (!s1_is_ref_reg && (nonref_tally_reg != '1))
            begin
                upd_nonref = nonref_tally_reg + CNT_W'(1);
            end
        end

        sum_hom_ref_next  = sum_hom_ref_reg;
        sum_het_next      = sum_het_reg;
        sum_hom_alt_next  = sum_hom_alt_reg;
        depth_count_next  = depth_count_reg;
        nonref_tally_next = nonref_tally_reg;
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                sum_hom_ref_next  = '0;
                sum_het_next      = '0;
                sum_hom_alt_next  = '0;
                depth_count_next  = '0;
                nonref_tally_next = '0;
            end
            else
            begin
                sum_hom_ref_next  = upd_hom_ref;
                sum_het_next      = upd_het;
                sum_hom_alt_next  = upd_hom_alt;
                depth_count_next  = upd_depth;
                nonref_tally_next = upd_nonref;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            sum_hom_ref_reg  <= '0;
            sum_het_reg      <= '0;
            sum_hom_alt_reg  <= '0;
            depth_count_reg  <= '0;
            nonref_tally_reg <= '0;
            fin_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            sum_hom_ref_reg  <= sum_hom_ref_next;
            sum_het_reg      <= sum_het_next;
            sum_hom_alt_reg  <= sum_hom_alt_next;
            depth_count_reg  <= depth_count_next;
            nonref_tally_reg <= nonref_tally_next;
            fin_valid_reg    <= fin_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        if (s1_fire && s1_last_reg)
        begin
            fin_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            fin_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            fin_hom_ref_reg <= upd_hom_ref;
            fin_het_reg     <= upd_het;
            fin_hom_alt_reg <= upd_hom_alt;
            fin_depth_reg   <= upd_depth;
            fin_nonref_reg  <= upd_nonref;
        end
    end

    // min-normalize, round half up, saturate to PL width
    always_comb
    begin
        min_sum = fin_hom_ref_reg;
        gt_pick = GT_HOM_REF;
        if (fin_het_reg < min_sum)
        begin
            min_sum = fin_het_reg;
            gt_pick = GT_HET;
        end
        if (fin_hom_alt_reg < min_sum)
        begin
            min_sum = fin_hom_alt_reg;
            gt_pick = GT_HOM_ALT;
        end
        if (fin_nonref_reg == '0)
        begin
            gt_pick = GT_HOM_REF;
        end

        rnd_hom_ref = ({1'b0, fin_hom_ref_reg - min_sum} + {1'b0, ROUND_HALF}) >> FRAC_BITS;
        rnd_het     = ({1'b0, fin_het_reg - min_sum} + {1'b0, ROUND_HALF}) >> FRAC_BITS;
        rnd_hom_alt = ({1'b0, fin_hom_alt_reg - min_sum} + {1'b0, ROUND_HALF}) >> FRAC_BITS;

        pl_hom_ref_next = (rnd_hom_ref > (SUM_W+1)'({PL_W{1'b1}})) ? '1 : rnd_hom_ref[PL_W-1:0];
        pl_het_next     = (rnd_het > (SUM_W+1)'({PL_W{1'b1}})) ? '1 : rnd_het[PL_W-1:0];
        pl_hom_alt_next = (rnd_hom_alt > (SUM_W+1)'({PL_W{1'b1}})) ? '1 : rnd_hom_alt[PL_W-1:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pl_hom_ref_reg   <= pl_hom_ref_next;
            pl_het_reg       <= pl_het_next;
            pl_hom_alt_reg   <= pl_hom_alt_next;
            genotype_reg     <= gt_pick;
            read_depth_reg   <= fin_depth_reg;
            nonref_count_reg <= fin_nonref_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pl_hom_ref   = pl_hom_ref_reg;
    assign pl_het       = pl_het_reg;
    assign pl_hom_alt   = pl_hom_alt_reg;
    assign genotype     = genotype_reg;
    assign read_depth   = read_depth_reg;
    assign nonref_count = nonref_count_reg;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (sum_hom_ref_reg == '0 && sum_het_reg == '0 &&
            sum_hom_alt_reg == '0 && depth_count_reg == '0 && nonref_tally_reg == '0))
        else $error("accumulators not cleared after closing transaction");

    a_nonref_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (nonref_count <= read_depth))
        else $error("nonref count exceeds read depth");

    a_no_alt_homref: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && nonref_count == '0) |-> (genotype == GT_HOM_REF))
        else $error("non-reference call without non-reference reads");

    a_called_pl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && nonref_count != '0) |->
            ((genotype == GT_HOM_REF && pl_hom_ref == '0) ||
             (genotype == GT_HET && pl_het == '0) ||
             (genotype == GT_HOM_ALT && pl_hom_alt == '0)))
        else $error("called genotype has nonzero PL");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(genotype) && $stable(pl_het)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
